// ----- rtl/core/nmit_pkg.sv -----
package nmit_pkg;

	// Fixed widths of the entry, cofactor, determinant and quotient datapaths.
	localparam int ENT_W = 32;
	localparam int COF_W = 64;
	localparam int DET_W = 98;
	localparam int QUO_W = 33;
	localparam int NUM_ENT = 9;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH = 2;

	// Entry indices of the two products that form each cofactor: a*b - c*d.
	typedef logic [3:0] idx_t;
	localparam idx_t COF_IDX [NUM_ENT][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic signed [ENT_W-1:0] m00;
		logic signed [ENT_W-1:0] m01;
		logic signed [ENT_W-1:0] m02;
		logic signed [ENT_W-1:0] m10;
		logic signed [ENT_W-1:0] m11;
		logic signed [ENT_W-1:0] m12;
		logic signed [ENT_W-1:0] m20;
		logic signed [ENT_W-1:0] m21;
		logic signed [ENT_W-1:0] m22;
	} in_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] n00;
		logic signed [ENT_W-1:0] n01;
		logic signed [ENT_W-1:0] n02;
		logic signed [ENT_W-1:0] n10;
		logic signed [ENT_W-1:0] n11;
		logic signed [ENT_W-1:0] n12;
		logic signed [ENT_W-1:0] n20;
		logic signed [ENT_W-1:0] n21;
		logic signed [ENT_W-1:0] n22;
		logic                    singular;
		logic                    saturated;
	} out_t;

	// Work handed from the front end to the divider back end.
	typedef struct packed {
		logic [NUM_ENT-1:0][COF_W-1:0] cof;
		logic [DET_W-1:0]              det;
	} work_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_PREP,
		BS_CHECK,
		BS_DIV,
		BS_DONE
	} bst_t;

endpackage

// ----- rtl/core/normal_matrix_inverse_transpose_core.sv -----
// Inverse transpose of a 3x3 signed fixed-point matrix (normal matrix). A
// transaction on the request channel carries nine entries with FRAC_BITS
// fraction bits; the response carries the nine entries of the inverse
// transpose, each the exact cofactor over the exact determinant, rounded to
// nearest with ties away from zero and clamped to 32 bits (saturated set),
// or all zeros with singular set when the determinant is zero. A five-stage
// front end forms the cofactors and determinant and accepts one request per
// cycle, unless its last stage is blocked, into a two-entry queue; the back
// end divides all nine entries at once with one quotient bit per cycle and
// takes the next work item from the queue only once the previous result has
// gone to its output register.
module normal_matrix_inverse_transpose_core #(
	parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  nmit_pkg::in_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nmit_pkg::out_t rsp_data
);

	logic            fe_valid, fe_ready;
	nmit_pkg::work_t fe_data;
	logic            be_valid, be_ready;
	nmit_pkg::work_t be_data;

	// Cofactor and determinant pipeline.
	nmit_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.wk_valid  (fe_valid),
		.wk_ready  (fe_ready),
		.wk_data   (fe_data)
	);

	// Queue between the front end and the divider.
	nmit_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_data  (fe_data),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_data   (be_data)
	);

	// Division, rounding and clamping.
	nmit_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wk_valid  (be_valid),
		.wk_ready  (be_ready),
		.wk_data   (be_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

`ifndef SYNTHESIS
	// The front end only stalls when its finished work cannot enter the queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (fe_valid && !fe_ready))
		else $error("front end stalled without a full queue");

	// A singular result has zero entries and no saturation.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.singular) |->
		(!rsp_data.saturated && rsp_data.n00 == '0 && rsp_data.n11 == '0
		&& rsp_data.n22 == '0))
		else $error("singular result with nonzero data");

	// A work item leaves the queue only when the divider is free.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(be_valid && be_ready) |=> !be_ready)
		else $error("divider took a second item while busy");
`endif

endmodule

// ----- rtl/core/nmit_front.sv -----
module nmit_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  nmit_pkg::in_t  req_data,
	output logic           wk_valid,
	input  logic           wk_ready,
	output nmit_pkg::work_t wk_data
);

	localparam int EW = nmit_pkg::ENT_W;
	localparam int CW = nmit_pkg::COF_W;
	localparam int DW = nmit_pkg::DET_W;
	localparam int NE = nmit_pkg::NUM_ENT;

	logic signed [EW-1:0]   m [NE];
	logic                   adv;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [2*EW-1:0] pa_s1 [NE];
	logic signed [2*EW-1:0] pb_s1 [NE];
	logic signed [EW-1:0]   e_s1 [3];
	logic signed [EW-1:0]   e_s2 [3];
	logic [CW-1:0]          cof_s2 [NE];
	logic [CW-1:0]          cof_s3 [NE];
	logic [CW-1:0]          cof_s4 [NE];
	logic [CW-1:0]          cof_s5 [NE];
	logic signed [EW:0]     lo_dummy;
	logic signed [EW+32:0]  lo_s3 [3];
	logic signed [CW-1:0]   hi_s3 [3];
	logic [DW-1:0]          term_s4 [3];
	logic [DW-1:0]          det_s5;

	assign m[0] = req_data.m00;
	assign m[1] = req_data.m01;
	assign m[2] = req_data.m02;
	assign m[3] = req_data.m10;
	assign m[4] = req_data.m11;
	assign m[5] = req_data.m12;
	assign m[6] = req_data.m20;
	assign m[7] = req_data.m21;
	assign m[8] = req_data.m22;
	assign lo_dummy = '0;

	// The whole pipeline moves together unless its last stage is blocked.
	assign adv       = !v_s5 || wk_ready;
	assign req_ready = adv;
	assign wk_valid  = v_s5;

	// Valid bits of the pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: the eighteen entry products. Stage 2: cofactors, wrapped to 64 bits.
	// Stage 3: split 32 by 64 determinant terms. Stage 4: terms. Stage 5: determinant.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NE; k++) begin
				pa_s1[k]  <= m[nmit_pkg::COF_IDX[k][0]] * m[nmit_pkg::COF_IDX[k][1]];
				pb_s1[k]  <= m[nmit_pkg::COF_IDX[k][2]] * m[nmit_pkg::COF_IDX[k][3]];
				cof_s2[k] <= pa_s1[k] - pb_s1[k];
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
			end
			for (int j = 0; j < 3; j++) begin
				e_s1[j]  <= m[j];
				e_s2[j]  <= e_s1[j];
				lo_s3[j] <= e_s2[j] * $signed({1'b0, cof_s2[j][31:0]});
				hi_s3[j] <= e_s2[j] * $signed(cof_s2[j][CW-1:32]);
				term_s4[j] <= {{(DW-CW-32){hi_s3[j][CW-1]}}, hi_s3[j], 32'd0}
					+ {{(DW-EW-33){lo_s3[j][EW+32]}}, lo_s3[j]}
					+ DW'(lo_dummy);
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		end
	end

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			wk_data.cof[k] = cof_s5[k];
		end
		wk_data.det = det_s5;
	end

endmodule

// ----- rtl/core/nmit_queue.sv -----
module nmit_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  nmit_pkg::work_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output nmit_pkg::work_t pop_data
);

	localparam int D  = nmit_pkg::QDEPTH;
	localparam int PW = $clog2(D);
	localparam int CNW = $clog2(D + 1);

	nmit_pkg::work_t   ent_q [D];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [CNW-1:0]    cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != CNW'(D);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = ent_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(D - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(D - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNW'(do_push) - CNW'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/nmit_back.sv -----
module nmit_back #(
	parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wk_valid,
	output logic            wk_ready,
	input  nmit_pkg::work_t wk_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output nmit_pkg::out_t  rsp_data
);

	localparam int EW  = nmit_pkg::ENT_W;
	localparam int CW  = nmit_pkg::COF_W;
	localparam int DW  = nmit_pkg::DET_W;
	localparam int QW  = nmit_pkg::QUO_W;
	localparam int NE  = nmit_pkg::NUM_ENT;
	localparam int NW  = DW + 1;
	localparam int SH  = 2 * FRAC_BITS + 1;
	localparam int XW  = (CW + SH + 1 > NW) ? CW + SH + 1 : NW;
	localparam int CNW = $clog2(QW + 1);

	nmit_pkg::bst_t state_q, state_d;
	logic [CW-1:0]  cof_q [NE];
	logic [DW-1:0]  det_q;
	logic [DW-1:0]  dmag_c;
	logic [DW-1:0]  dmag_q;
	logic [NW-1:0]  den;
	logic           zero_q;
	logic [XW-1:0]  x_q [NE];
	logic [NW-1:0]  rem_q [NE];
	logic [QW-1:0]  quo_q [NE];
	logic [NE-1:0]  neg_q;
	logic [NE-1:0]  ovf_q;
	logic [CNW-1:0] cnt_q;
	logic           out_free;
	logic           done_fire;
	logic [EW-1:0]  res [NE];
	logic [NE-1:0]  sat;
	logic           out_valid_q;
	nmit_pkg::out_t out_q;

	assign dmag_c    = det_q[DW-1] ? -det_q : det_q;
	assign den       = {dmag_q, 1'b0};
	assign out_free  = !out_valid_q || rsp_ready;
	assign done_fire = (state_q == nmit_pkg::BS_DONE) && out_free;
	assign wk_ready  = state_q == nmit_pkg::BS_IDLE;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nmit_pkg::BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: fetch, prepare, range check and shared-step division (both skipped for a zero determinant), deliver.
	always_comb begin
		state_d = state_q;
		case (state_q)
			nmit_pkg::BS_IDLE: begin
				if (wk_valid) state_d = nmit_pkg::BS_PREP;
			end
			nmit_pkg::BS_PREP: begin
				state_d = (det_q == '0) ? nmit_pkg::BS_DONE : nmit_pkg::BS_CHECK;
			end
			nmit_pkg::BS_CHECK: begin
				state_d = nmit_pkg::BS_DIV;
			end
			nmit_pkg::BS_DIV: begin
				if (cnt_q == CNW'(1)) state_d = nmit_pkg::BS_DONE;
			end
			nmit_pkg::BS_DONE: begin
				if (out_free) state_d = nmit_pkg::BS_IDLE;
			end
			default: begin
				state_d = nmit_pkg::BS_IDLE;
			end
		endcase
	end

	// Nine division lanes, one quotient bit per lane per cycle.
	always_ff @(posedge clk) begin
		logic [NW:0] trial;
		logic [CW-1:0] magc;
		case (state_q)
			nmit_pkg::BS_IDLE: begin
				for (int i = 0; i < NE; i++) begin
					cof_q[i] <= wk_data.cof[i];
				end
				det_q <= wk_data.det;
			end
			nmit_pkg::BS_PREP: begin
				dmag_q <= dmag_c;
				zero_q <= det_q == '0;
				for (int i = 0; i < NE; i++) begin
					magc = cof_q[i][CW-1] ? -cof_q[i] : cof_q[i];
					x_q[i]   <= (XW'(magc) << SH) + XW'(dmag_c);
					neg_q[i] <= cof_q[i][CW-1] != det_q[DW-1];
				end
			end
			nmit_pkg::BS_CHECK: begin
				cnt_q <= CNW'(QW);
				for (int i = 0; i < NE; i++) begin
					ovf_q[i] <= (x_q[i] >> QW) >= den;
					rem_q[i] <= NW'(x_q[i] >> QW);
					quo_q[i] <= '0;
				end
			end
			nmit_pkg::BS_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				for (int i = 0; i < NE; i++) begin
					trial = {rem_q[i], x_q[i][QW-1]};
					x_q[i] <= x_q[i] << 1;
					if (trial >= {1'b0, den}) begin
						rem_q[i] <= NW'(trial - {1'b0, den});
						quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
					end else begin
						rem_q[i] <= trial[NW-1:0];
						quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Apply sign, clamp to the entry range, or force zeros for a singular matrix.
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			res[i] = '0;
			sat[i] = 1'b0;
			if (!zero_q) begin
				if (neg_q[i]) begin
					if (ovf_q[i] || quo_q[i] > QW'({1'b1, {(EW-1){1'b0}}})) begin
						res[i] = {1'b1, {(EW-1){1'b0}}};
						sat[i] = 1'b1;
					end else begin
						res[i] = -quo_q[i][EW-1:0];
					end
				end else begin
					if (ovf_q[i] || quo_q[i][QW-1:EW-1] != '0) begin
						res[i] = {1'b0, {(EW-1){1'b1}}};
						sat[i] = 1'b1;
					end else begin
						res[i] = quo_q[i][EW-1:0];
					end
				end
			end
		end
	end

	// Output register, so a waiting result does not hold up the next fetch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q.n00       <= res[0];
			out_q.n01       <= res[1];
			out_q.n02       <= res[2];
			out_q.n10       <= res[3];
			out_q.n11       <= res[4];
			out_q.n12       <= res[5];
			out_q.n20       <= res[6];
			out_q.n21       <= res[7];
			out_q.n22       <= res[8];
			out_q.singular  <= zero_q;
			out_q.saturated <= |sat;
		end
	end

endmodule
